// ----- hdl/mau_pkg.sv -----
package mau_pkg;

  // Operation codes carried in req_type
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_POW = 2'd3;

  // Modulus after reset
  localparam int unsigned RESET_MODULUS = 7;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RED_A   = 9'b000000010,
    S_RED_B   = 9'b000000100,
    S_ARITH   = 9'b000001000,
    S_MUL     = 9'b000010000,
    S_POW_CHK = 9'b000100000,
    S_POW_MA  = 9'b001000000,
    S_POW_SQ  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

endpackage

// ----- hdl/modular_arithmetic_unit.sv -----
// Modular add, subtract, multiply and power against the modulus register,
// one request at a time. Operands are reduced modulo q by a bit-serial
// multiply-by-one, and multiplications run through one shared bit-serial
// interleaved multiplier. Add and subtract reduce both operands and then
// combine them; multiply adds one more product. Power reduces both operands,
// then for each exponent bit below the highest set one it squares, and also
// multiplies where the bit is set; the highest set bit gets a multiply and
// is not squared. The result becomes valid as the sequencer returns to idle,
// ready for the next request. The shared multiplier sets the rate. A new
// request is accepted while the last result still waits in the output
// register. A modulus of zero returns 0.
module modular_arithmetic_unit #(
  parameter int VALUE_WIDTH = 16,
  parameter int EXP_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             req_type,
  input  logic [VALUE_WIDTH-1:0] operand_a,
  input  logic [VALUE_WIDTH-1:0] operand_b,
  input  logic [EXP_WIDTH-1:0]   exponent,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] result
);

  mau_pkg::state_t state;

  logic [VALUE_WIDTH-1:0] modulus;
  logic [1:0]             op;
  logic [VALUE_WIDTH-1:0] a_val;   // reduced a, then running square
  logic [VALUE_WIDTH-1:0] b_val;
  logic [VALUE_WIDTH-1:0] res;     // result, power accumulator
  logic [EXP_WIDTH-1:0]   e;

  logic                   mul_start;
  logic [VALUE_WIDTH-1:0] mul_x;
  logic [VALUE_WIDTH-1:0] mul_y;
  logic                   mul_done;
  logic [VALUE_WIDTH-1:0] mul_prod;

  logic [VALUE_WIDTH-1:0] one_q;
  logic [VALUE_WIDTH:0]   add_s;
  logic [VALUE_WIDTH:0]   add_r;
  logic [VALUE_WIDTH:0]   sub_d;
  logic [VALUE_WIDTH-1:0] arith_res;

  mau_mulser #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .q    (modulus),
    .done (mul_done),
    .prod (mul_prod)
  );

  // 1 mod q, also the unit multiplier for reduction
  assign one_q = VALUE_WIDTH'(modulus != VALUE_WIDTH'(1));

  // Add / subtract on reduced operands
  always_comb begin
    add_s = {1'b0, a_val} + {1'b0, b_val};
    add_r = (add_s >= {1'b0, modulus}) ? (add_s - {1'b0, modulus}) : add_s;
    sub_d = {1'b0, a_val} - {1'b0, b_val};
    if (op == mau_pkg::OP_ADD) begin
      arith_res = add_r[VALUE_WIDTH-1:0];
    end else if (sub_d[VALUE_WIDTH]) begin
      arith_res = sub_d[VALUE_WIDTH-1:0] + modulus;
    end else begin
      arith_res = sub_d[VALUE_WIDTH-1:0];
    end
  end

  assign in_ready = (state == mau_pkg::S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mau_pkg::S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      modulus   <= VALUE_WIDTH'(mau_pkg::RESET_MODULUS);
    end else begin
      if (cfg_we) begin
        modulus <= cfg_wdata;
      end

      // Multiplier launch on every state that issues a product
      mul_start <= ((state == mau_pkg::S_IDLE) && in_valid && (modulus != '0)) ||
                   ((state == mau_pkg::S_RED_A) && mul_done) ||
                   ((state == mau_pkg::S_RED_B) && mul_done && (op == mau_pkg::OP_MUL)) ||
                   ((state == mau_pkg::S_POW_CHK) && (e != '0)) ||
                   ((state == mau_pkg::S_POW_MA) && mul_done && ((e >> 1) != '0));

      // Output register: load a finished result, clear on handshake
      if ((state == mau_pkg::S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        mau_pkg::S_IDLE: begin
          if (in_valid) begin
            op    <= req_type;
            b_val <= operand_b;
            e     <= exponent;
            if (modulus == '0) begin
              res   <= '0;
              state <= mau_pkg::S_DONE;
            end else begin
              mul_x     <= operand_a;
              mul_y     <= one_q;
              state     <= mau_pkg::S_RED_A;
            end
          end
        end

        mau_pkg::S_RED_A: begin
          if (mul_done) begin
            a_val     <= mul_prod;
            mul_x     <= b_val;
            mul_y     <= one_q;
            state     <= mau_pkg::S_RED_B;
          end
        end

        mau_pkg::S_RED_B: begin
          if (mul_done) begin
            b_val <= mul_prod;
            case (op)
              mau_pkg::OP_MUL: begin
                mul_x     <= a_val;
                mul_y     <= mul_prod;
                state     <= mau_pkg::S_MUL;
              end
              mau_pkg::OP_POW: begin
                res   <= one_q;
                state <= mau_pkg::S_POW_CHK;
              end
              default: begin
                state <= mau_pkg::S_ARITH;
              end
            endcase
          end
        end

        mau_pkg::S_ARITH: begin
          res   <= arith_res;
          state <= mau_pkg::S_DONE;
        end

        mau_pkg::S_MUL: begin
          if (mul_done) begin
            res   <= mul_prod;
            state <= mau_pkg::S_DONE;
          end
        end

        // Square-and-multiply, exponent LSB first
        mau_pkg::S_POW_CHK: begin
          if (e == '0) begin
            state <= mau_pkg::S_DONE;
          end else if (e[0]) begin
            mul_x     <= res;
            mul_y     <= a_val;
            state     <= mau_pkg::S_POW_MA;
          end else begin
            mul_x     <= a_val;
            mul_y     <= a_val;
            state     <= mau_pkg::S_POW_SQ;
          end
        end

        mau_pkg::S_POW_MA: begin
          if (mul_done) begin
            res <= mul_prod;
            if ((e >> 1) == '0) begin
              state <= mau_pkg::S_DONE;
            end else begin
              mul_x     <= a_val;
              mul_y     <= a_val;
              state     <= mau_pkg::S_POW_SQ;
            end
          end
        end

        mau_pkg::S_POW_SQ: begin
          if (mul_done) begin
            a_val <= mul_prod;
            e     <= e >> 1;
            state <= mau_pkg::S_POW_CHK;
          end
        end

        mau_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            result    <= res;
            state     <= mau_pkg::S_IDLE;
          end
        end

        default: begin
          state <= mau_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/mau_mulser.sv -----
module mau_mulser #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] x,
  input  logic [VALUE_WIDTH-1:0] y,
  input  logic [VALUE_WIDTH-1:0] q,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] prod
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] xs;
  logic [VALUE_WIDTH-1:0] ys;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;

  logic [VALUE_WIDTH:0] q1;
  logic [VALUE_WIDTH:0] dbl;
  logic [VALUE_WIDTH:0] dbl_red;
  logic [VALUE_WIDTH:0] sum;
  logic [VALUE_WIDTH:0] sum_red;

  // One multiplier bit per cycle, MSB first: acc = 2*acc + bit*y, mod q
  always_comb begin
    q1      = {1'b0, q};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= q1) ? (dbl - q1) : dbl;
    sum     = dbl_red + (xs[VALUE_WIDTH-1] ? {1'b0, ys} : '0);
    sum_red = (sum >= q1) ? (sum - q1) : sum;
    acc_next = sum_red[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        xs   <= x;
        ys   <= y;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        xs  <= {xs[VALUE_WIDTH-2:0], 1'b0};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign prod = acc;

endmodule
